[hw/rtl/lsact_pkg.sv]
// Shared constants, register and opcode codes, and scan interface types.
`timescale 1ns / 1ps
`default_nettype none
package lsact_pkg;

    // Geometry of the tag store.
    localparam int unsigned MAX_SET_BITS = 6;
    localparam int unsigned MAX_WAYS     = 8;
    localparam int unsigned ADDR_WIDTH   = 64;

    localparam int unsigned SET_BITS   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int unsigned SET_COUNT  = 1 << SET_BITS;
    localparam int unsigned WAY_BITS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned WAY_CNT_W  = WAY_BITS + 1;
    localparam int unsigned LINE_BITS  = SET_BITS + WAY_BITS;
    localparam int unsigned LINE_COUNT = 1 << LINE_BITS;

    // Field widths fixed by the interface.
    localparam int unsigned ADDR_PORT_W = 64;
    localparam int unsigned TAG_W       = 64;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned TOTAL_W     = 32;
    localparam int unsigned CFG_DATA_W  = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned SETB_W      = 3;
    localparam int unsigned WAYS_W      = 4;
    localparam int unsigned OFFB_W      = 6;

    localparam logic [ADDR_PORT_W-1:0] ADDR_MASK = {ADDR_PORT_W{1'b1}} >> (64 - ADDR_WIDTH);

    // Opcodes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_IFETCH = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS    = 2'd2;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic                hit_now;
        logic                found;
        logic                have_invalid;
        logic [WAY_BITS-1:0] victim;
    } scan_status_t;

endpackage
`default_nettype wire

[hw/rtl/lru_set_assoc_cache_tracker.sv]
// Top level: sequencer, tag, stamp and valid stores, running totals and result register.
//
//  Channel   Signals                                   Direction  Content
//  access    access_valid/access_stall, opcode,address  in         one memory access
//  result    result_valid/result_stall, six fields      out        per-access flags, totals
//  config    cfg_write_enable, cfg_index, cfg_data      in         geometry registers
//
// An access runs through PREP, SCAN over W ways and UPDATE, W being the ways compared
// before a hit or the last way in use (up to 8): one shared compare unit visits one way
// per cycle from the tag and stamp memory ports. An instruction fetch is accepted but gives no result.
// Reset clears all valid bits at once through per-set row flags; no clearing pass.
// A new access is taken while the previous result waits; the write-back waits
// only if the result register is still full.
`timescale 1ns / 1ps
`default_nettype none
module lru_set_assoc_cache_tracker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   access_valid,
    output logic                                        access_stall,
    input  wire logic [1:0]                             opcode,
    input  wire logic [lsact_pkg::ADDR_PORT_W-1:0]      address,
    output logic                                        result_valid,
    input  wire logic                                   result_stall,
    output logic [1:0]                                  hits_this_access,
    output logic                                        missed,
    output logic                                        evicted,
    output logic [lsact_pkg::TOTAL_W-1:0]               total_hits,
    output logic [lsact_pkg::TOTAL_W-1:0]               total_misses,
    output logic [lsact_pkg::TOTAL_W-1:0]               total_evictions,
    input  wire logic                                   cfg_write_enable,
    input  wire logic [lsact_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [lsact_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]                          state_reg;
    logic [lsact_pkg::SETB_W-1:0]        set_index_bits_reg;
    logic [lsact_pkg::WAYS_W-1:0]        ways_in_use_reg;
    logic [lsact_pkg::OFFB_W-1:0]        offset_bits_reg;
    logic [lsact_pkg::WAY_BITS-1:0]      way_reg;
    logic [1:0]                          op_reg;
    logic [lsact_pkg::TAG_W-1:0]         block_reg;
    logic [lsact_pkg::SET_COUNT-1:0]     row_written_reg;
    logic [lsact_pkg::STAMP_W-1:0]       access_counter_reg;
    logic [lsact_pkg::TOTAL_W-1:0]       hit_total_reg;
    logic [lsact_pkg::TOTAL_W-1:0]       miss_total_reg;
    logic [lsact_pkg::TOTAL_W-1:0]       eviction_total_reg;
    logic                                result_valid_reg;
    logic [1:0]                          hits_reg;
    logic                                missed_reg;
    logic                                evicted_reg;

    logic                                access_accept;
    logic                                update_go;
    logic [lsact_pkg::SETB_W-1:0]        set_bits_eff;
    logic [lsact_pkg::SET_BITS:0]        set_mask_wide;
    logic [lsact_pkg::SET_BITS-1:0]      set_idx;
    logic [lsact_pkg::WAY_CNT_W-1:0]     ways_eff;
    logic                                last_way;
    logic [lsact_pkg::WAY_BITS-1:0]      rd_way;
    logic [lsact_pkg::LINE_BITS-1:0]     rd_line;
    logic [lsact_pkg::LINE_BITS-1:0]     wr_line;
    logic [lsact_pkg::TAG_W-1:0]         tag_q;
    logic [lsact_pkg::STAMP_W-1:0]       stamp_q;
    logic [lsact_pkg::MAX_WAYS-1:0]      valid_q;
    logic [lsact_pkg::MAX_WAYS-1:0]      valid_row;
    logic [lsact_pkg::MAX_WAYS-1:0]      valid_wdata;
    lsact_pkg::scan_ctrl_t               scan_ctrl;
    lsact_pkg::scan_status_t             scan_status;
    logic [1:0]                          hits_now;
    logic                                miss_now;
    logic                                evict_now;
    logic [lsact_pkg::TOTAL_W:0]         hit_sum;
    logic [lsact_pkg::TOTAL_W:0]         miss_sum;
    logic [lsact_pkg::TOTAL_W:0]         evict_sum;

    assign access_stall  = (state_reg != ST_IDLE);
    assign access_accept = access_valid && !access_stall;
    assign update_go     = (state_reg == ST_UPDATE) && (!result_valid_reg || !result_stall);

    // Effective geometry.
    assign set_bits_eff  = (32'(set_index_bits_reg) > lsact_pkg::MAX_SET_BITS)
                         ? lsact_pkg::SETB_W'(lsact_pkg::MAX_SET_BITS) : set_index_bits_reg;
    assign set_mask_wide = ({{lsact_pkg::SET_BITS{1'b0}}, 1'b1} << set_bits_eff)
                         - {{lsact_pkg::SET_BITS{1'b0}}, 1'b1};
    assign set_idx       = block_reg[lsact_pkg::SET_BITS-1:0]
                         & set_mask_wide[lsact_pkg::SET_BITS-1:0];
    assign ways_eff      = (ways_in_use_reg == '0) ? lsact_pkg::WAY_CNT_W'(1)
                         : (32'(ways_in_use_reg) > lsact_pkg::MAX_WAYS)
                           ? lsact_pkg::WAY_CNT_W'(lsact_pkg::MAX_WAYS)
                           : lsact_pkg::WAY_CNT_W'(ways_in_use_reg);
    assign last_way      = ({1'b0, way_reg} + lsact_pkg::WAY_CNT_W'(1)) == ways_eff;

    // Memory reads run one way ahead of the compare unit.
    assign rd_way  = (state_reg == ST_PREP) ? way_reg : way_reg + lsact_pkg::WAY_BITS'(1);
    assign rd_line = {set_idx, rd_way};
    assign wr_line = {set_idx, scan_status.victim};

    // A set never written since reset reads as all lines empty.
    assign valid_row   = row_written_reg[set_idx] ? valid_q : '0;
    assign valid_wdata = valid_row | (lsact_pkg::MAX_WAYS'(1) << scan_status.victim);

    assign scan_ctrl.clear = (state_reg == ST_PREP);
    assign scan_ctrl.step  = (state_reg == ST_SCAN);

    lsact_ram #(
        .WIDTH (lsact_pkg::TAG_W),
        .DEPTH (lsact_pkg::LINE_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (update_go && !scan_status.found),
        .waddr (wr_line),
        .wdata (block_reg),
        .raddr (rd_line),
        .rdata (tag_q)
    );

    lsact_ram #(
        .WIDTH (lsact_pkg::STAMP_W),
        .DEPTH (lsact_pkg::LINE_COUNT)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (update_go),
        .waddr (wr_line),
        .wdata (access_counter_reg),
        .raddr (rd_line),
        .rdata (stamp_q)
    );

    lsact_ram #(
        .WIDTH (lsact_pkg::MAX_WAYS),
        .DEPTH (lsact_pkg::SET_COUNT)
    ) u_valid_ram (
        .clk   (clk),
        .we    (update_go && !scan_status.found),
        .waddr (set_idx),
        .wdata (valid_wdata),
        .raddr (set_idx),
        .rdata (valid_q)
    );

    lsact_way_scan u_way_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .way        (way_reg),
        .line_valid (valid_row[way_reg]),
        .tag        (tag_q),
        .block      (block_reg),
        .stamp      (stamp_q),
        .counter    (access_counter_reg),
        .status     (scan_status)
    );

    // Per-access outcome and saturating totals.
    always_comb
    begin
        if (scan_status.found)
        begin
            hits_now = (op_reg == lsact_pkg::OP_MODIFY) ? 2'd2 : 2'd1;
        end
        else
        begin
            hits_now = (op_reg == lsact_pkg::OP_MODIFY) ? 2'd1 : 2'd0;
        end
        miss_now  = !scan_status.found;
        evict_now = !scan_status.found && !scan_status.have_invalid;
        hit_sum   = {1'b0, hit_total_reg} + (lsact_pkg::TOTAL_W + 1)'(hits_now);
        miss_sum  = {1'b0, miss_total_reg} + (lsact_pkg::TOTAL_W + 1)'(miss_now);
        evict_sum = {1'b0, eviction_total_reg} + (lsact_pkg::TOTAL_W + 1)'(evict_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            set_index_bits_reg <= '0;
            ways_in_use_reg    <= lsact_pkg::WAYS_W'(1);
            offset_bits_reg    <= '0;
            way_reg            <= '0;
            row_written_reg    <= '0;
            access_counter_reg <= '0;
            hit_total_reg      <= '0;
            miss_total_reg     <= '0;
            eviction_total_reg <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    lsact_pkg::CFG_SET_INDEX_BITS:
                        set_index_bits_reg <= cfg_data[lsact_pkg::SETB_W-1:0];
                    lsact_pkg::CFG_WAYS_IN_USE:
                        ways_in_use_reg <= cfg_data[lsact_pkg::WAYS_W-1:0];
                    lsact_pkg::CFG_OFFSET_BITS:
                        offset_bits_reg <= cfg_data[lsact_pkg::OFFB_W-1:0];
                    default:
                        ;
                endcase
            end

            // A new word may load in the same cycle the previous one is taken.
            if (update_go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (access_accept && (opcode != lsact_pkg::OP_IFETCH))
                    begin
                        way_reg   <= '0;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_status.hit_now || last_way)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        way_reg <= way_reg + lsact_pkg::WAY_BITS'(1);
                    end
                end
                ST_UPDATE:
                begin
                    if (update_go)
                    begin
                        if (!scan_status.found)
                        begin
                            row_written_reg[set_idx] <= 1'b1;
                        end
                        access_counter_reg <= access_counter_reg + lsact_pkg::STAMP_W'(1);
                        hit_total_reg      <= hit_sum[lsact_pkg::TOTAL_W]
                                            ? '1 : hit_sum[lsact_pkg::TOTAL_W-1:0];
                        miss_total_reg     <= miss_sum[lsact_pkg::TOTAL_W]
                                            ? '1 : miss_sum[lsact_pkg::TOTAL_W-1:0];
                        eviction_total_reg <= evict_sum[lsact_pkg::TOTAL_W]
                                            ? '1 : evict_sum[lsact_pkg::TOTAL_W-1:0];
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (access_accept)
        begin
            op_reg    <= opcode;
            block_reg <= (address & lsact_pkg::ADDR_MASK) >> offset_bits_reg;
        end
        if (update_go)
        begin
            hits_reg    <= hits_now;
            missed_reg  <= miss_now;
            evicted_reg <= evict_now;
        end
    end

    assign result_valid     = result_valid_reg;
    assign hits_this_access = hits_reg;
    assign missed           = missed_reg;
    assign evicted          = evicted_reg;
    assign total_hits       = hit_total_reg;
    assign total_misses     = miss_total_reg;
    assign total_evictions  = eviction_total_reg;

endmodule
`default_nettype wire

[hw/rtl/lsact_ram.sv]
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module lsact_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/lsact_way_scan.sv]
// Shared way compare unit: tag match, age compare and victim tracking, one way per step.
`timescale 1ns / 1ps
`default_nettype none
module lsact_way_scan (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lsact_pkg::scan_ctrl_t               ctrl,
    input  wire logic [lsact_pkg::WAY_BITS-1:0]      way,
    input  wire logic                                line_valid,
    input  wire logic [lsact_pkg::TAG_W-1:0]         tag,
    input  wire logic [lsact_pkg::TAG_W-1:0]         block,
    input  wire logic [lsact_pkg::STAMP_W-1:0]       stamp,
    input  wire logic [lsact_pkg::STAMP_W-1:0]       counter,
    output lsact_pkg::scan_status_t                  status
);

    logic                               found_reg;
    logic                               have_invalid_reg;
    logic                               have_valid_reg;
    logic [lsact_pkg::STAMP_W-1:0]      best_age_reg;
    logic [lsact_pkg::WAY_BITS-1:0]     victim_reg;
    logic                               hit_now;
    logic [lsact_pkg::STAMP_W-1:0]      age;

    assign hit_now = line_valid && (tag == block);
    // The age wraps modulo 2^32, matching the free-running access counter.
    assign age     = counter - stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            have_invalid_reg <= 1'b0;
            have_valid_reg   <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg        <= 1'b0;
            have_invalid_reg <= 1'b0;
            have_valid_reg   <= 1'b0;
        end
        else if (ctrl.step)
        begin
            if (hit_now)
            begin
                found_reg <= 1'b1;
            end
            else if (!line_valid)
            begin
                have_invalid_reg <= 1'b1;
            end
            else if (!have_invalid_reg)
            begin
                have_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            if (hit_now)
            begin
                victim_reg <= way;
            end
            else if (!line_valid)
            begin
                // Only the first empty way is taken.
                if (!have_invalid_reg)
                begin
                    victim_reg <= way;
                end
            end
            else if (!have_invalid_reg)
            begin
                // Strictly older wins, so the lowest way keeps a tie.
                if (!have_valid_reg || (age > best_age_reg))
                begin
                    best_age_reg <= age;
                    victim_reg   <= way;
                end
            end
        end
    end

    assign status.hit_now      = hit_now;
    assign status.found        = found_reg;
    assign status.have_invalid = have_invalid_reg;
    assign status.victim       = victim_reg;

endmodule
`default_nettype wire
